@@ src/bba_pkg.sv @@
// Shared types and constants of the buddy block allocator.
// Depends on nothing; bba_seq, buddy_block_allocator and bba_checker import it.
package bba_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LOG2  = 2'd1;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SIZE  = 2'd1,
		ST_NO_BLOCK  = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FIT,
		S_SCAN,
		S_SPLIT,
		S_PROBE,
		S_CHECK,
		S_MREAD,
		S_MCHECK,
		S_DONE
	} state_t;

	// Effective pool size and tree depth, derived from the configuration registers.
	typedef struct packed {
		logic [5:0] pool_log2;
		logic [4:0] depth;
	} cfg_t;

endpackage

@@ src/bba_tree_ram.sv @@
// One-bit-wide node memory of the allocator tree, one write port and two read ports.
// Read data is registered. Depends on nothing.
module bba_tree_ram #(
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic          rdata_a,
	output logic          rdata_b
);

	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ src/bba_seq.sv @@
// Sequencer of the allocator: clearing pass, allocate scan and split, free and merge.
// Depends on bba_pkg and drives the ports of bba_tree_ram.
module bba_seq #(
	parameter int MAX_LEVELS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bba_pkg::cfg_t           cfg,
	input  logic                    clear_req,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    mode,
	input  logic [31:0]             request_size,
	input  logic [31:0]             block_offset,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [31:0]             result_offset,
	output logic [4:0]              block_level,
	output logic [32:0]             bytes_in_use,
	output logic                    mem_we,
	output logic [MAX_LEVELS:0]     mem_waddr,
	output logic                    mem_wdata,
	output logic [MAX_LEVELS:0]     mem_raddr_a,
	output logic [MAX_LEVELS:0]     mem_raddr_b,
	input  logic                    mem_rdata_a,
	input  logic                    mem_rdata_b
);
	import bba_pkg::*;

	localparam int AW = MAX_LEVELS + 1;
	localparam int PW = MAX_LEVELS;
	localparam int LW = $clog2(MAX_LEVELS + 1);

	state_t          state_q, state_d;
	logic [LW-1:0]   lvl_q, lvl_tgt_q;
	logic [PW-1:0]   pos_q, j_q, j_s1;
	logic            issue_done_q, vld_s1, last_s1, phase_q;
	logic [31:0]     size_q, off_q;
	logic [32:0]     bytes_q;
	logic [AW-1:0]   clr_addr_q;
	status_t         st_q;
	logic [31:0]     roff_q;
	logic [4:0]      rlev_q;
	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [31:0]     out_offset_q;
	logic [4:0]      out_level_q;
	logic [32:0]     out_bytes_q;

	logic [5:0]      sh_w;
	logic [32:0]     blk_w, offs_w;
	logic [33:0]     sum_w;
	logic            fits_w, align_w, hit_w, last_w, out_free_w;
	logic [PW-1:0]   pos_f_w, hit_pos_w, last_j_w;
	logic [LW-1:0]   depth_w;

	function automatic logic [AW-1:0] node_addr(input logic [LW-1:0] l, input logic [PW-1:0] p);
		node_addr = ((AW'(1) << l) - AW'(1)) + AW'(p);
	endfunction

	assign depth_w  = LW'(cfg.depth);
	assign sh_w     = cfg.pool_log2 - 6'(lvl_q);
	assign blk_w    = 33'd1 << sh_w;
	assign fits_w   = blk_w >= {1'b0, size_q};
	assign pos_f_w  = PW'(off_q >> sh_w);
	assign align_w  = ({1'b0, off_q} & (blk_w - 33'd1)) == 33'd0;
	assign offs_w   = 33'(pos_q) << sh_w;
	assign sum_w    = {1'b0, bytes_q} + {1'b0, blk_w};
	assign last_j_w = (lvl_q == '0) ? '0 : PW'((AW'(1) << (lvl_q - LW'(1))) - AW'(1));
	assign last_w   = j_q == last_j_w;
	assign out_free_w = !out_valid_q || !out_stall;

	always_comb begin
		hit_w     = 1'b0;
		hit_pos_w = '0;
		if (lvl_q == '0) begin
			hit_w = !mem_rdata_a;
		end else if (!mem_rdata_a && mem_rdata_b) begin
			hit_w     = 1'b1;
			hit_pos_w = PW'({j_s1, 1'b0});
		end else if (mem_rdata_a && !mem_rdata_b) begin
			hit_w     = 1'b1;
			hit_pos_w = PW'({j_s1, 1'b1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_waddr   = node_addr(lvl_q, pos_q);
		mem_wdata   = 1'b0;
		mem_raddr_a = node_addr(lvl_q, pos_q);
		mem_raddr_b = node_addr(lvl_q, pos_q);
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_addr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_ALLOC) begin
						if (request_size == '0 ||
						    {1'b0, request_size} > (33'd1 << cfg.pool_log2)) begin
							state_d = S_DONE;
						end else begin
							state_d = S_FIT;
						end
					end else if ({1'b0, block_offset} < (33'd1 << cfg.pool_log2)) begin
						state_d = S_PROBE;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_FIT: begin
				if (fits_w) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (lvl_q == '0) begin
					mem_raddr_a = '0;
					mem_raddr_b = '0;
				end else begin
					mem_raddr_a = node_addr(lvl_q, '0) + AW'({j_q, 1'b0});
					mem_raddr_b = node_addr(lvl_q, '0) + AW'({j_q, 1'b1});
				end
				if (vld_s1 && hit_w) begin
					state_d = S_SPLIT;
				end else if (vld_s1 && last_s1 && lvl_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_SPLIT: begin
				mem_we = 1'b1;
				if (!phase_q) begin
					mem_wdata = 1'b1;
					if (lvl_q == lvl_tgt_q) begin
						state_d = S_DONE;
					end
				end else begin
					mem_waddr = node_addr(lvl_q + LW'(1), PW'({pos_q, 1'b1}));
				end
			end
			S_PROBE: begin
				mem_raddr_a = node_addr(lvl_q, pos_f_w);
				if (align_w) begin
					state_d = S_CHECK;
				end else if (lvl_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_CHECK: begin
				if (mem_rdata_a) begin
					mem_we  = 1'b1;
					state_d = (lvl_q == '0) ? S_DONE : S_MREAD;
				end else begin
					state_d = (lvl_q == '0) ? S_DONE : S_PROBE;
				end
			end
			S_MREAD: begin
				mem_raddr_a = node_addr(lvl_q, pos_q ^ PW'(1));
				state_d     = S_MCHECK;
			end
			S_MCHECK: begin
				if (!mem_rdata_a) begin
					mem_we    = 1'b1;
					mem_waddr = node_addr(lvl_q - LW'(1), pos_q >> 1);
					state_d   = (lvl_q == LW'(1)) ? S_DONE : S_MREAD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free_w) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		if (clear_req) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			bytes_q      <= '0;
			vld_s1       <= 1'b0;
			issue_done_q <= 1'b0;
			phase_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free_w && !clear_req) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clear_req) begin
				clr_addr_q <= '0;
				bytes_q    <= '0;
				vld_s1     <= 1'b0;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
					S_IDLE: begin
						size_q <= request_size;
						off_q  <= block_offset;
						lvl_q  <= depth_w;
						st_q   <= (mode == MODE_ALLOC) ? ST_BAD_SIZE : ST_NOT_ALLOC;
						roff_q <= '0;
						rlev_q <= '0;
					end
					S_FIT: begin
						if (fits_w) begin
							lvl_tgt_q    <= lvl_q;
							j_q          <= '0;
							issue_done_q <= 1'b0;
							vld_s1       <= 1'b0;
						end else begin
							lvl_q <= lvl_q - LW'(1);
						end
					end
					S_SCAN: begin
						if (vld_s1 && hit_w) begin
							pos_q   <= hit_pos_w;
							phase_q <= 1'b0;
							vld_s1  <= 1'b0;
						end else if (vld_s1 && last_s1) begin
							vld_s1 <= 1'b0;
							if (lvl_q == '0) begin
								st_q <= ST_NO_BLOCK;
							end else begin
								lvl_q        <= lvl_q - LW'(1);
								j_q          <= '0;
								issue_done_q <= 1'b0;
							end
						end else begin
							vld_s1 <= !issue_done_q;
							if (!issue_done_q) begin
								j_s1         <= j_q;
								last_s1      <= last_w;
								j_q          <= j_q + PW'(1);
								issue_done_q <= last_w;
							end
						end
					end
					S_SPLIT: begin
						if (!phase_q) begin
							if (lvl_q == lvl_tgt_q) begin
								bytes_q <= sum_w[33] ? '1 : sum_w[32:0];
								st_q    <= ST_OK;
								roff_q  <= offs_w[31:0];
								rlev_q  <= 5'(lvl_q);
							end else begin
								phase_q <= 1'b1;
							end
						end else begin
							phase_q <= 1'b0;
							lvl_q   <= lvl_q + LW'(1);
							pos_q   <= PW'({pos_q, 1'b0});
						end
					end
					S_PROBE: begin
						pos_q <= pos_f_w;
						if (!align_w && lvl_q != '0) begin
							lvl_q <= lvl_q - LW'(1);
						end
					end
					S_CHECK: begin
						if (mem_rdata_a) begin
							bytes_q <= (bytes_q > blk_w) ? bytes_q - blk_w : '0;
							st_q    <= ST_OK;
							roff_q  <= off_q;
							rlev_q  <= 5'(lvl_q);
						end else if (lvl_q != '0) begin
							lvl_q <= lvl_q - LW'(1);
						end
					end
					S_MREAD: begin
					end
					S_MCHECK: begin
						if (!mem_rdata_a) begin
							lvl_q <= lvl_q - LW'(1);
							pos_q <= pos_q >> 1;
						end
					end
					S_DONE: begin
						if (out_free_w) begin
							out_status_q <= st_q;
							out_offset_q <= roff_q;
							out_level_q  <= rlev_q;
							out_bytes_q  <= bytes_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign in_stall      = state_q != S_IDLE;
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign result_offset = out_offset_q;
	assign block_level   = out_level_q;
	assign bytes_in_use  = out_bytes_q;

endmodule

@@ src/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: configuration registers, node memory, sequencer.
// Depends on bba_pkg, bba_tree_ram and bba_seq.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    mode, request_size, block_offset
//   out      out_valid / out_stall  status, result_offset, block_level, bytes_in_use
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction is in work at a time. A free probes from the deepest level toward the
// root for an aligned allocated node, clears it and merges free buddies upward. An
// allocate finds the deepest level that fits, scans node pairs up toward the root and
// splits the block found. After reset and after a write to REG_POOL_LOG2 or REG_MIN_LOG2,
// a clearing pass sweeps the node memory while input is stalled; writes are always taken.
// A stalled result waits in the output register while the next input is taken.
module buddy_block_allocator #(
	parameter int MAX_LEVELS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [31:0]                       request_size,
	input  logic [31:0]                       block_offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [31:0]                       result_offset,
	output logic [4:0]                        block_level,
	output logic [32:0]                       bytes_in_use,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bba_pkg::*;

	localparam int AW = MAX_LEVELS + 1;

	logic [5:0]    pool_log2_q;
	logic [4:0]    min_log2_q;
	logic [5:0]    pool_eff_w, depth_raw_w;
	logic          clear_w;
	cfg_t          cfg_w;
	logic          mem_we, mem_wdata, mem_rdata_a, mem_rdata_b;
	logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;

	assign cfg_ready = 1'b1;
	assign clear_w   = cfg_valid && (cfg_index == REG_POOL_LOG2 || cfg_index == REG_MIN_LOG2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_log2_q <= 6'd16;
			min_log2_q  <= 5'd6;
		end else if (cfg_valid) begin
			if (cfg_index == REG_POOL_LOG2) begin
				pool_log2_q <= cfg_data[5:0];
			end else if (cfg_index == REG_MIN_LOG2) begin
				min_log2_q <= cfg_data[4:0];
			end
		end
	end

	always_comb begin
		priority if (pool_log2_q < 6'd1) begin
			pool_eff_w = 6'd1;
		end else if (pool_log2_q > 6'd32) begin
			pool_eff_w = 6'd32;
		end else begin
			pool_eff_w = pool_log2_q;
		end
		depth_raw_w = (pool_eff_w > 6'(min_log2_q)) ? pool_eff_w - 6'(min_log2_q) : 6'd0;
		cfg_w.pool_log2 = pool_eff_w;
		cfg_w.depth = (depth_raw_w > 6'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : depth_raw_w[4:0];
	end

	bba_tree_ram #(
		.AW(AW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	bba_seq #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_w),
		.clear_req     (clear_w),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.request_size  (request_size),
		.block_offset  (block_offset),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.result_offset (result_offset),
		.block_level   (block_level),
		.bytes_in_use  (bytes_in_use),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr_a   (mem_raddr_a),
		.mem_raddr_b   (mem_raddr_b),
		.mem_rdata_a   (mem_rdata_a),
		.mem_rdata_b   (mem_rdata_b)
	);

endmodule

@@ src/bba_checker.sv @@
// Port-level checks of the buddy block allocator, bound to its top level.
// Depends on bba_pkg and buddy_block_allocator.
module bba_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [1:0]                        status,
	input logic [31:0]                       result_offset,
	input logic [4:0]                        block_level,
	input logic [32:0]                       bytes_in_use,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);
	import bba_pkg::*;

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_offset)
		&& $stable(block_level) && $stable(bytes_in_use))
		else $error("stalled result changed");

	// A failed transaction reports neither offset nor level.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_offset == '0 && block_level == '0)
		else $error("error result carries offset or level");

	// One transaction is in work at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// Register writes are never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.result_offset (result_offset),
	.block_level   (block_level),
	.bytes_in_use  (bytes_in_use),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
